/* src/video_unit_register_interface_unit_macros.svh */
// Assertion macros used by the video register interface top-level module.
`ifndef VIDEO_UNIT_REGISTER_INTERFACE_UNIT_MACROS_SVH
`define VIDEO_UNIT_REGISTER_INTERFACE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define VURI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define VURI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vuri_pkg.sv */
// Shared constants, codes and types of the video register interface.
`timescale 1ns / 1ps
package vuri_pkg;

    localparam int PATTERN_BYTES   = 8192;
    localparam int NAMETABLE_BYTES = 4096;
    localparam int SPRITE_BYTES    = 256;

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);

    // item kinds
    localparam logic [2:0] ACT_READ        = 3'd0;
    localparam logic [2:0] ACT_WRITE       = 3'd1;
    localparam logic [2:0] ACT_FRAME_START = 3'd2;
    localparam logic [2:0] ACT_VBLANK      = 3'd3;
    localparam logic [2:0] ACT_LINE_START  = 3'd4;
    localparam logic [2:0] ACT_LINE_END    = 3'd5;

    // register numbers
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SPR_ADR = 3'd3;
    localparam logic [2:0] REG_SPR_DAT = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // mirroring codes
    localparam logic [2:0] MIR_SINGLE_0   = 3'd0;
    localparam logic [2:0] MIR_SINGLE_1   = 3'd1;
    localparam logic [2:0] MIR_SINGLE_2   = 3'd2;
    localparam logic [2:0] MIR_SINGLE_3   = 3'd3;
    localparam logic [2:0] MIR_VERTICAL   = 3'd4;
    localparam logic [2:0] MIR_HORIZONTAL = 3'd5;
    localparam logic [2:0] MIR_RESET      = MIR_VERTICAL;

    localparam logic [13:0] VRAM_MASK_NT  = 14'h2000;
    localparam logic [13:0] VRAM_PALETTE  = 14'h3F00;
    localparam logic [15:0] STEP_ROW      = 16'd32;
    localparam logic [15:0] FINE_Y_STEP   = 16'h1000;
    localparam logic [15:0] NT_V_FLIP     = 16'h0800;
    localparam logic [15:0] NT_V_BACK     = 16'h0400;
    localparam logic [4:0]  COARSE_Y_LAST = 5'd30;
    localparam logic [15:0] COARSE_Y_SPAN = 16'd960;

    typedef struct packed {
        logic              spr_we;
        logic              spr_re;
        logic [SPR_AW-1:0] spr_addr;
        logic              pat_we;
        logic              pat_re;
        logic [PAT_AW-1:0] pat_addr;
        logic              nt_we;
        logic              nt_re;
        logic [NT_AW-1:0]  nt_addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] rd_stored;
        logic       nmi;
        logic       sel_sprite;
        logic       refill;
        logic       refill_nt;
    } item_res_t;

endpackage

/* src/video_unit_register_interface_unit.sv */
// Top level of the video register interface: memories, result stage and handshakes.
//
//  channel   | direction | beat contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | tuser: action; tdata: reg_index, write_data
//  m_axis    | out       | tdata: read_data, nmi_request
//  cfg       | in        | mirroring_mode write, taken whenever cfg_we is high
//
//  One item per cycle while s_tready is high; a result passes the memory read stage,
//  then the output register, and a low m_tready can hold it in either.
//  After reset a clearing pass zeroes all memories, one address per cycle over
//  CLR_DEPTH addresses (the largest memory depth), with s_tready low throughout.
//  A low m_tready holds the output register, then the read stage, then drops s_tready.
`timescale 1ns / 1ps
module video_unit_register_interface_unit #(
    parameter int PATTERN_BYTES   = vuri_pkg::PATTERN_BYTES,
    parameter int NAMETABLE_BYTES = vuri_pkg::NAMETABLE_BYTES,
    parameter int SPRITE_BYTES    = vuri_pkg::SPRITE_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] reg_index, [10:3] write_data
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [8] nmi_request
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata
);

`include "video_unit_register_interface_unit_macros.svh"

    localparam int PAT_AW    = $clog2(PATTERN_BYTES);
    localparam int NT_AW     = $clog2(NAMETABLE_BYTES);
    localparam int SPR_AW    = $clog2(SPRITE_BYTES);
    localparam int CLR_DEPTH = (PATTERN_BYTES > NAMETABLE_BYTES) ?
                               ((PATTERN_BYTES > SPRITE_BYTES) ? PATTERN_BYTES : SPRITE_BYTES) :
                               ((NAMETABLE_BYTES > SPRITE_BYTES) ? NAMETABLE_BYTES : SPRITE_BYTES);
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    logic                clearing_reg;
    logic [CLR_AW-1:0]   clr_cnt_reg;
    logic                accept;
    logic                s2_move;
    logic                s2_valid_reg;
    vuri_pkg::item_res_t s2_reg;
    vuri_pkg::item_res_t s1_res;
    vuri_pkg::mem_req_t  mem_req;
    logic [7:0]          read_buffer_reg;
    logic [7:0]          read_buffer_fwd;
    logic [7:0]          refill_data;
    logic [7:0]          s2_rd;
    logic [7:0]          out_rd_reg;
    logic                out_nmi_reg;
    logic                out_valid_reg;
    logic [7:0]          spr_rdata, pat_rdata, nt_rdata;

    assign s2_move  = ~out_valid_reg | m_tready;
    assign s_tready = ~clearing_reg & (~s2_valid_reg | s2_move);
    assign accept   = s_tvalid & s_tready;

    // a refill still in the read stage is the buffer the next item sees
    assign refill_data     = s2_reg.refill_nt ? nt_rdata : pat_rdata;
    assign read_buffer_fwd = (s2_valid_reg && s2_reg.refill) ? refill_data : read_buffer_reg;
    assign s2_rd           = s2_reg.sel_sprite ? spr_rdata : s2_reg.rd_stored;

    vuri_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .action      (s_tuser),
        .reg_index   (s_tdata[2:0]),
        .write_data  (s_tdata[10:3]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .read_buffer (read_buffer_fwd),
        .mem_req     (mem_req),
        .res         (s1_res)
    );

    vuri_ram #(.DEPTH(SPRITE_BYTES), .WIDTH(8)) u_spr_ram (
        .aclk  (aclk),
        .we    (clearing_reg | mem_req.spr_we),
        .re    (mem_req.spr_re),
        .addr  (clearing_reg ? SPR_AW'(clr_cnt_reg) : SPR_AW'(mem_req.spr_addr)),
        .wdata (clearing_reg ? 8'd0 : mem_req.wdata),
        .rdata (spr_rdata)
    );

    vuri_ram #(.DEPTH(PATTERN_BYTES), .WIDTH(8)) u_pat_ram (
        .aclk  (aclk),
        .we    (clearing_reg | mem_req.pat_we),
        .re    (mem_req.pat_re),
        .addr  (clearing_reg ? PAT_AW'(clr_cnt_reg) : PAT_AW'(mem_req.pat_addr)),
        .wdata (clearing_reg ? 8'd0 : mem_req.wdata),
        .rdata (pat_rdata)
    );

    vuri_ram #(.DEPTH(NAMETABLE_BYTES), .WIDTH(8)) u_nt_ram (
        .aclk  (aclk),
        .we    (clearing_reg | mem_req.nt_we),
        .re    (mem_req.nt_re),
        .addr  (clearing_reg ? NT_AW'(clr_cnt_reg) : NT_AW'(mem_req.nt_addr)),
        .wdata (clearing_reg ? 8'd0 : mem_req.wdata),
        .rdata (nt_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            read_buffer_reg <= 8'd0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            // an empty read stage loads even while the output register is stalled
            if (s2_move || !s2_valid_reg) begin
                s2_valid_reg <= accept;
            end
            if (s2_valid_reg && s2_move && s2_reg.refill) begin
                read_buffer_reg <= refill_data;
            end
            if (s2_valid_reg && s2_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_reg <= s1_res;
        end
        if (s2_valid_reg && s2_move) begin
            out_rd_reg  <= s2_rd;
            out_nmi_reg <= s2_reg.nmi;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_nmi_reg, out_rd_reg};

    `VURI_ASSERT_NOW(a_no_accept_clearing, clearing_reg, !accept, "item taken during clearing pass")
    `VURI_ASSERT_NEXT(a_s2_holds, s2_valid_reg && !s2_move, s2_valid_reg, "read stage dropped a stalled item")
    `VURI_ASSERT_NOW(a_refill_not_sprite, s2_valid_reg && s2_reg.refill, !s2_reg.sel_sprite, "refill item also selects sprite data")
    `VURI_ASSERT_NOW(a_nmi_no_data, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'd0, "interrupt beat carries read data")
    `VURI_ASSERT_NOW(a_clear_full, $fell(clearing_reg), $past(clr_cnt_reg) == CLR_AW'(CLR_DEPTH - 1), "clearing pass ended early")

endmodule

/* src/vuri_ram.sv */
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module vuri_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_q [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_q[addr] <= wdata;
        end
        // hold read data until the next read
        if (re) begin
            rdata_reg <= mem_q[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/vuri_ctrl.sv */
// Register file state, item decode and memory request generation.
`timescale 1ns / 1ps
module vuri_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [2:0]          action,
    input  logic [2:0]          reg_index,
    input  logic [7:0]          write_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,
    input  logic [7:0]          read_buffer,
    output vuri_pkg::mem_req_t  mem_req,
    output vuri_pkg::item_res_t res
);

    logic [2:0]  mode_reg;
    logic [15:0] va_reg, va_next;
    logic [14:0] temp_reg, temp_next;
    logic        sw_reg, sw_next;
    logic        row_reg, row_next;
    logic        nmi_en_reg, nmi_en_next;
    logic        bg_reg, bg_next;
    logic        spr_on_reg, spr_on_next;
    logic        vbf_reg, vbf_next;
    logic        invb_reg, invb_next;
    logic [vuri_pkg::SPR_AW-1:0] sa_reg, sa_next;

    logic        rendering;
    logic [15:0] va_step;
    logic [13:0] vram;
    logic [1:0]  slot;
    logic [1:0]  blk;
    logic [15:0] le1, le2, le_addr;
    logic [7:0]  status;

    always_comb begin
        rendering = bg_reg | spr_on_reg;
        va_step   = va_reg + (row_reg ? vuri_pkg::STEP_ROW : 16'd1);
        vram      = va_reg[13:0];
        slot      = vram[11:10];
        case (mode_reg) inside
            vuri_pkg::MIR_SINGLE_0, vuri_pkg::MIR_SINGLE_1,
            vuri_pkg::MIR_SINGLE_2, vuri_pkg::MIR_SINGLE_3: blk = mode_reg[1:0];
            vuri_pkg::MIR_VERTICAL:   blk = {1'b0, slot[0]};
            vuri_pkg::MIR_HORIZONTAL: blk = {1'b0, slot[1]};
            default:                  blk = slot;
        endcase

        // fine Y, then coarse Y with name-table wrap
        le1 = va_reg + vuri_pkg::FINE_Y_STEP;
        le2 = le1 + vuri_pkg::STEP_ROW;
        if (le1[14:12] != 3'd0) begin
            le_addr = le1;
        end else if (le2[9:5] == 5'd0) begin
            le_addr = le2 - vuri_pkg::NT_V_BACK;
        end else if (le2[9:5] == vuri_pkg::COARSE_Y_LAST) begin
            le_addr = (le2 - vuri_pkg::COARSE_Y_SPAN) ^ vuri_pkg::NT_V_FLIP;
        end else begin
            le_addr = le2;
        end

        status = {vbf_reg, invb_reg, 1'b0, ~invb_reg & rendering, 4'd0};

        va_next     = va_reg;
        temp_next   = temp_reg;
        sw_next     = sw_reg;
        row_next    = row_reg;
        nmi_en_next = nmi_en_reg;
        bg_next     = bg_reg;
        spr_on_next = spr_on_reg;
        vbf_next    = vbf_reg;
        invb_next   = invb_reg;
        sa_next     = sa_reg;

        mem_req          = '0;
        mem_req.spr_addr = sa_reg;
        mem_req.pat_addr = vram[vuri_pkg::PAT_AW-1:0];
        mem_req.nt_addr  = vuri_pkg::NT_AW'({blk, vram[9:0]});
        mem_req.wdata    = write_data;
        res              = '0;

        if (accept) begin
            unique case (action)
                vuri_pkg::ACT_READ: begin
                    unique case (reg_index)
                        vuri_pkg::REG_STATUS: begin
                            res.rd_stored = status;
                            vbf_next      = 1'b0;
                            sw_next       = 1'b0;
                        end
                        vuri_pkg::REG_SPR_DAT: begin
                            mem_req.spr_re = 1'b1;
                            res.sel_sprite = 1'b1;
                            sa_next        = sa_reg + 1'b1;
                        end
                        vuri_pkg::REG_DATA: begin
                            res.rd_stored = read_buffer;
                            res.refill    = 1'b1;
                            if (vram < vuri_pkg::VRAM_MASK_NT) begin
                                mem_req.pat_re = 1'b1;
                            end else begin
                                mem_req.nt_re  = 1'b1;
                                res.refill_nt  = 1'b1;
                            end
                            va_next = va_step;
                        end
                        default: ;
                    endcase
                end
                vuri_pkg::ACT_WRITE: begin
                    unique case (reg_index)
                        vuri_pkg::REG_CTRL: begin
                            nmi_en_next     = write_data[7];
                            row_next        = write_data[2];
                            temp_next[11:10] = write_data[1:0];
                        end
                        vuri_pkg::REG_MASK: begin
                            bg_next     = write_data[3];
                            spr_on_next = write_data[4];
                        end
                        vuri_pkg::REG_SPR_ADR: sa_next = write_data;
                        vuri_pkg::REG_SPR_DAT: begin
                            mem_req.spr_we = 1'b1;
                            sa_next        = sa_reg + 1'b1;
                        end
                        vuri_pkg::REG_SCROLL: begin
                            sw_next = ~sw_reg;
                            if (!sw_reg) begin
                                temp_next[4:0] = write_data[7:3];
                            end else begin
                                temp_next[9:5]   = write_data[7:3];
                                temp_next[14:12] = write_data[2:0];
                            end
                        end
                        vuri_pkg::REG_ADDR: begin
                            sw_next = ~sw_reg;
                            if (!sw_reg) begin
                                temp_next = {1'b0, write_data[5:0], temp_reg[7:0]};
                            end else begin
                                temp_next = {temp_reg[14:8], write_data};
                                va_next   = {1'b0, temp_reg[14:8], write_data};
                            end
                        end
                        vuri_pkg::REG_DATA: begin
                            // palette range stores nothing
                            if (vram < vuri_pkg::VRAM_MASK_NT) begin
                                mem_req.pat_we = 1'b1;
                            end else if (vram < vuri_pkg::VRAM_PALETTE) begin
                                mem_req.nt_we = 1'b1;
                            end
                            va_next = va_step;
                        end
                        default: ;
                    endcase
                end
                vuri_pkg::ACT_FRAME_START: begin
                    vbf_next  = 1'b0;
                    invb_next = 1'b0;
                    if (rendering) begin
                        va_next = {1'b0, temp_reg};
                    end
                end
                vuri_pkg::ACT_VBLANK: begin
                    vbf_next  = 1'b1;
                    invb_next = 1'b1;
                    res.nmi   = nmi_en_reg;
                end
                vuri_pkg::ACT_LINE_START: begin
                    if (rendering) begin
                        va_next[10]  = temp_reg[10];
                        va_next[4:0] = temp_reg[4:0];
                    end
                end
                vuri_pkg::ACT_LINE_END: begin
                    if (rendering) begin
                        va_next = le_addr;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= vuri_pkg::MIR_RESET;
            va_reg     <= '0;
            temp_reg   <= '0;
            sw_reg     <= 1'b0;
            row_reg    <= 1'b0;
            nmi_en_reg <= 1'b1;
            bg_reg     <= 1'b0;
            spr_on_reg <= 1'b0;
            vbf_reg    <= 1'b0;
            invb_reg   <= 1'b0;
            sa_reg     <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            va_reg     <= va_next;
            temp_reg   <= temp_next;
            sw_reg     <= sw_next;
            row_reg    <= row_next;
            nmi_en_reg <= nmi_en_next;
            bg_reg     <= bg_next;
            spr_on_reg <= spr_on_next;
            vbf_reg    <= vbf_next;
            invb_reg   <= invb_next;
            sa_reg     <= sa_next;
        end
    end

endmodule
